// ----- hw/rtl/qfv_pkg.sv -----
package qfv_pkg;

	localparam int unsigned POSITION_BITS_DEF = 32;

	localparam logic [31:0] FNV_BASIS = 32'd2166136261;
	localparam logic [31:0] FNV_PRIME = 32'd16777619;
	localparam logic [7:0]  MAGIC_S   = 8'h53;
	localparam logic [7:0]  MAGIC_Q   = 8'h51;
	localparam logic [7:0]  VERSION_RECEIVED = 8'd2;

	localparam logic [7:0]  NEWEST_VERSION_RST = 8'd2;
	localparam logic [7:0]  MAX_ENTRIES_RST    = 8'd16;
	localparam logic [7:0]  ID_MAX_RST         = 8'd32;
	localparam logic [7:0]  TITLE_MAX_RST      = 8'd64;
	localparam logic [15:0] VALUE_MAX_RST      = 16'd256;

	typedef enum logic [2:0] {
		REG_NEWEST_VERSION = 3'd0,
		REG_MAX_ENTRIES    = 3'd1,
		REG_ID_MAX         = 3'd2,
		REG_TITLE_MAX      = 3'd3,
		REG_VALUE_MAX      = 3'd4
	} reg_index_t;

	typedef enum logic [3:0] {
		ST_OK        = 4'd0,
		ST_SHORT     = 4'd1,
		ST_CHECKSUM  = 4'd2,
		ST_MAGIC     = 4'd3,
		ST_VERSION   = 4'd4,
		ST_COUNT     = 4'd5,
		ST_TEXT_LONG = 4'd6,
		ST_TRUNCATED = 4'd7,
		ST_TRAILING  = 4'd8
	} status_t;

	typedef enum logic [3:0] {
		PH_MAGIC0    = 4'd0,
		PH_MAGIC1    = 4'd1,
		PH_VERSION   = 4'd2,
		PH_COUNT     = 4'd3,
		PH_KIND      = 4'd4,
		PH_FONT      = 4'd5,
		PH_COLOR     = 4'd6,
		PH_DURATION  = 4'd7,
		PH_RECEIVED  = 4'd8,
		PH_IDLEN     = 4'd9,
		PH_IDTEXT    = 4'd10,
		PH_TITLELEN  = 4'd11,
		PH_TITLETEXT = 4'd12,
		PH_VALLEN    = 4'd13,
		PH_VALTEXT   = 4'd14,
		PH_DONE      = 4'd15
	} phase_t;

	typedef struct packed {
		logic [7:0]  newest_version;
		logic [7:0]  max_entries;
		logic [7:0]  id_max_length;
		logic [7:0]  title_max_length;
		logic [15:0] value_max_length;
	} cfg_t;

	typedef struct packed {
		phase_t      phase;
		logic [1:0]  fbi;
		logic [7:0]  version;
		logic [7:0]  count;
		logic [7:0]  done;
		logic [15:0] remaining;
		logic        too_long;
		status_t     err;
		logic [7:0]  kind;
		logic [7:0]  font_size;
		logic [7:0]  color;
		logic [31:0] duration_s;
		logic [31:0] received_at;
		logic [7:0]  id_length;
		logic [7:0]  title_length;
		logic [15:0] value_length;
	} parse_t;

	localparam parse_t PARSE_RST = '{
		phase: PH_MAGIC0, fbi: 2'd0, version: 8'd0, count: 8'd0, done: 8'd0,
		remaining: 16'd0, too_long: 1'b0, err: ST_OK, kind: 8'd0, font_size: 8'd0,
		color: 8'd0, duration_s: 32'd0, received_at: 32'd0, id_length: 8'd0,
		title_length: 8'd0, value_length: 16'd0
	};

endpackage

// ----- hw/rtl/qfv_parser.sv -----
module qfv_parser (
	input  qfv_pkg::parse_t cur,
	input  qfv_pkg::cfg_t   cfg,
	input  logic [7:0]      data,
	output qfv_pkg::parse_t nxt,
	output logic            entry_done
);

	logic        start;
	logic        fin;
	logic [15:0] len;
	logic [15:0] lim;
	qfv_pkg::phase_t text_ph;
	logic [7:0]  done_inc;

	assign done_inc = cur.done + 8'd1;

	always_comb begin
		nxt        = cur;
		entry_done = 1'b0;
		start      = 1'b0;
		fin        = 1'b0;
		len        = 16'd0;
		lim        = 16'd0;
		text_ph    = qfv_pkg::PH_IDTEXT;
		if (cur.err == qfv_pkg::ST_OK) begin
			unique case (cur.phase)
				qfv_pkg::PH_MAGIC0: begin
					if (data != qfv_pkg::MAGIC_S) nxt.err = qfv_pkg::ST_MAGIC;
					else nxt.phase = qfv_pkg::PH_MAGIC1;
				end
				qfv_pkg::PH_MAGIC1: begin
					if (data != qfv_pkg::MAGIC_Q) nxt.err = qfv_pkg::ST_MAGIC;
					else nxt.phase = qfv_pkg::PH_VERSION;
				end
				qfv_pkg::PH_VERSION: begin
					nxt.version = data;
					if (data == 8'd0 || data > cfg.newest_version) nxt.err = qfv_pkg::ST_VERSION;
					else nxt.phase = qfv_pkg::PH_COUNT;
				end
				qfv_pkg::PH_COUNT: begin
					nxt.count = data;
					if (data > cfg.max_entries) nxt.err = qfv_pkg::ST_COUNT;
					else nxt.phase = (data == 8'd0) ? qfv_pkg::PH_DONE : qfv_pkg::PH_KIND;
				end
				qfv_pkg::PH_KIND: begin
					nxt.kind         = data;
					nxt.font_size    = 8'd0;
					nxt.color        = 8'd0;
					nxt.duration_s   = 32'd0;
					nxt.received_at  = 32'd0;
					nxt.id_length    = 8'd0;
					nxt.title_length = 8'd0;
					nxt.value_length = 16'd0;
					nxt.phase        = qfv_pkg::PH_FONT;
				end
				qfv_pkg::PH_FONT: begin
					nxt.font_size = data;
					nxt.phase     = qfv_pkg::PH_COLOR;
				end
				qfv_pkg::PH_COLOR: begin
					nxt.color = data;
					nxt.fbi   = 2'd0;
					nxt.phase = qfv_pkg::PH_DURATION;
				end
				qfv_pkg::PH_DURATION: begin
					nxt.duration_s[{cur.fbi, 3'b000} +: 8] = data;
					nxt.fbi = cur.fbi + 2'd1;
					if (cur.fbi == 2'd3) begin
						nxt.phase = (cur.version >= qfv_pkg::VERSION_RECEIVED) ?
							qfv_pkg::PH_RECEIVED : qfv_pkg::PH_IDLEN;
					end
				end
				qfv_pkg::PH_RECEIVED: begin
					nxt.received_at[{cur.fbi, 3'b000} +: 8] = data;
					nxt.fbi = cur.fbi + 2'd1;
					if (cur.fbi == 2'd3) nxt.phase = qfv_pkg::PH_IDLEN;
				end
				qfv_pkg::PH_IDLEN: begin
					nxt.id_length = data;
					start   = 1'b1;
					len     = {8'd0, data};
					lim     = {8'd0, cfg.id_max_length};
					text_ph = qfv_pkg::PH_IDTEXT;
				end
				qfv_pkg::PH_TITLELEN: begin
					nxt.title_length = data;
					start   = 1'b1;
					len     = {8'd0, data};
					lim     = {8'd0, cfg.title_max_length};
					text_ph = qfv_pkg::PH_TITLETEXT;
				end
				qfv_pkg::PH_VALLEN: begin
					if (cur.fbi == 2'd0) begin
						nxt.value_length[7:0] = data;
						nxt.fbi = 2'd1;
					end else begin
						nxt.value_length[15:8] = data;
						nxt.fbi = 2'd0;
						start   = 1'b1;
						len     = {data, cur.value_length[7:0]};
						lim     = cfg.value_max_length;
						text_ph = qfv_pkg::PH_VALTEXT;
					end
				end
				qfv_pkg::PH_IDTEXT, qfv_pkg::PH_TITLETEXT, qfv_pkg::PH_VALTEXT: begin
					nxt.remaining = cur.remaining - 16'd1;
					fin = (cur.remaining == 16'd1);
				end
				default: nxt.err = qfv_pkg::ST_TRAILING;
			endcase
			if (start) begin
				nxt.phase     = text_ph;
				nxt.remaining = len;
				nxt.too_long  = (len > lim);
				fin           = (len == 16'd0);
			end
			if (fin) begin
				if (nxt.too_long) begin
					nxt.err = qfv_pkg::ST_TEXT_LONG;
				end else if (nxt.phase == qfv_pkg::PH_IDTEXT) begin
					nxt.phase = qfv_pkg::PH_TITLELEN;
				end else if (nxt.phase == qfv_pkg::PH_TITLETEXT) begin
					nxt.phase = qfv_pkg::PH_VALLEN;
					nxt.fbi   = 2'd0;
				end else begin
					nxt.done   = done_inc;
					nxt.phase  = (done_inc == cur.count) ? qfv_pkg::PH_DONE : qfv_pkg::PH_KIND;
					entry_done = 1'b1;
				end
			end
		end
	end

endmodule

// ----- hw/rtl/queue_frame_validator_unit.sv -----
// an input transfer's result shows in the output register in the cycle after the transfer
// throughput: one byte per cycle while the output side takes results
// one fnv-1a constant multiply and the parser step sit between state and result registers
// arst_n low clears frame state, output valid and loads register reset values
// frame state returns to reset after every last byte, registers are kept
module queue_frame_validator_unit #(
	parameter int unsigned POSITION_BITS = qfv_pkg::POSITION_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        last_byte,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        is_status,
	output logic [7:0]  kind,
	output logic [7:0]  font_size,
	output logic [7:0]  color,
	output logic [31:0] duration_s,
	output logic [31:0] received_at,
	output logic [7:0]  id_length,
	output logic [7:0]  title_length,
	output logic [15:0] value_length,
	output logic [7:0]  entry_index,
	output logic [3:0]  status_code,
	output logic [7:0]  entry_count
);

	localparam logic [POSITION_BITS-1:0] POS_MAX = '1;
	localparam logic [POSITION_BITS-1:0] POS_FOUR = POSITION_BITS'(4);
	localparam logic [POSITION_BITS-1:0] POS_EIGHT = POSITION_BITS'(8);

	qfv_pkg::cfg_t   cfg_q;
	qfv_pkg::parse_t parse_q;
	qfv_pkg::parse_t parse_nxt;
	qfv_pkg::parse_t parse_d;
	logic [7:0]      delay_q [4];
	logic [31:0]     hash_q;
	logic [31:0]     hash_mul;
	logic [31:0]     hash_d;
	logic [POSITION_BITS-1:0] pos_q;
	logic [POSITION_BITS-1:0] pos_d;
	logic            active;
	logic            accept;
	logic            entry_done;
	logic            done_d;
	logic [31:0]     chk;
	qfv_pkg::status_t code;
	logic            produce;
	logic            out_valid_q;

	assign cfg_ready = 1'b1;
	assign in_stall  = out_valid_q & out_stall;
	assign accept    = in_valid & ~in_stall;
	assign out_valid = out_valid_q;
	assign active    = (pos_q >= POS_FOUR);

	qfv_parser u_parser (
		.cur        (parse_q),
		.cfg        (cfg_q),
		.data       (delay_q[0]),
		.nxt        (parse_nxt),
		.entry_done (entry_done)
	);

	assign hash_mul = (hash_q ^ {24'd0, delay_q[0]}) * qfv_pkg::FNV_PRIME;
	assign hash_d   = active ? hash_mul : hash_q;
	assign parse_d  = active ? parse_nxt : parse_q;
	assign done_d   = active & entry_done;
	assign pos_d    = (pos_q == POS_MAX) ? pos_q : pos_q + POSITION_BITS'(1);
	assign chk      = {data_byte, delay_q[3], delay_q[2], delay_q[1]};
	assign produce  = last_byte | done_d;

	always_comb begin
		priority if (pos_d < POS_EIGHT) code = qfv_pkg::ST_SHORT;
		else if (chk != hash_d) code = qfv_pkg::ST_CHECKSUM;
		else if (parse_d.err != qfv_pkg::ST_OK) code = parse_d.err;
		else if (parse_d.phase != qfv_pkg::PH_DONE) code = qfv_pkg::ST_TRUNCATED;
		else code = qfv_pkg::ST_OK;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.newest_version   <= qfv_pkg::NEWEST_VERSION_RST;
			cfg_q.max_entries      <= qfv_pkg::MAX_ENTRIES_RST;
			cfg_q.id_max_length    <= qfv_pkg::ID_MAX_RST;
			cfg_q.title_max_length <= qfv_pkg::TITLE_MAX_RST;
			cfg_q.value_max_length <= qfv_pkg::VALUE_MAX_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				qfv_pkg::REG_NEWEST_VERSION: cfg_q.newest_version   <= cfg_data[7:0];
				qfv_pkg::REG_MAX_ENTRIES:    cfg_q.max_entries      <= cfg_data[7:0];
				qfv_pkg::REG_ID_MAX:         cfg_q.id_max_length    <= cfg_data[7:0];
				qfv_pkg::REG_TITLE_MAX:      cfg_q.title_max_length <= cfg_data[7:0];
				qfv_pkg::REG_VALUE_MAX:      cfg_q.value_max_length <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			parse_q <= qfv_pkg::PARSE_RST;
			hash_q  <= qfv_pkg::FNV_BASIS;
			pos_q   <= '0;
			for (int i = 0; i < 4; i++) delay_q[i] <= 8'd0;
		end else if (accept) begin
			if (last_byte) begin
				parse_q <= qfv_pkg::PARSE_RST;
				hash_q  <= qfv_pkg::FNV_BASIS;
				pos_q   <= '0;
				for (int i = 0; i < 4; i++) delay_q[i] <= 8'd0;
			end else begin
				parse_q    <= parse_d;
				hash_q     <= hash_d;
				pos_q      <= pos_d;
				delay_q[0] <= delay_q[1];
				delay_q[1] <= delay_q[2];
				delay_q[2] <= delay_q[3];
				delay_q[3] <= data_byte;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!in_stall) begin
			out_valid_q <= accept & produce;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && produce) begin
			is_status    <= last_byte;
			kind         <= done_d ? parse_d.kind : 8'd0;
			font_size    <= done_d ? parse_d.font_size : 8'd0;
			color        <= done_d ? parse_d.color : 8'd0;
			duration_s   <= done_d ? parse_d.duration_s : 32'd0;
			received_at  <= done_d ? parse_d.received_at : 32'd0;
			id_length    <= done_d ? parse_d.id_length : 8'd0;
			title_length <= done_d ? parse_d.title_length : 8'd0;
			value_length <= done_d ? parse_d.value_length : 16'd0;
			entry_index  <= done_d ? parse_d.done - 8'd1 : 8'd0;
			status_code  <= last_byte ? code : qfv_pkg::ST_OK;
			entry_count  <= last_byte ? parse_d.count : 8'd0;
		end
	end

`ifndef SYNTHESIS
	a_stall_needs_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid)
		else $error("input stalled without a pending result");
	a_frame_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && last_byte) |=> (parse_q.phase == qfv_pkg::PH_MAGIC0 && pos_q == '0))
		else $error("frame state not cleared after last byte");
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(accept))
		else $error("result appeared without an input transfer");
	a_no_descriptor_after_error: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !last_byte && parse_q.err != qfv_pkg::ST_OK) |=> !out_valid)
		else $error("descriptor emitted after an error");
`endif

endmodule

// ----- test/tb_queue_frame_validator_unit.sv -----
`timescale 1ns / 100ps

module tb_queue_frame_validator_unit;

	typedef struct packed {
		logic        is_status;
		logic [7:0]  kind;
		logic [7:0]  font_size;
		logic [7:0]  color;
		logic [31:0] duration_s;
		logic [31:0] received_at;
		logic [7:0]  id_length;
		logic [7:0]  title_length;
		logic [15:0] value_length;
		logic [7:0]  entry_index;
		logic [3:0]  status_code;
		logic [7:0]  entry_count;
	} frame_res_t;

	typedef enum int {FR_GOOD, FR_CORRUPT, FR_CUT, FR_EXTRA, FR_BADSUM, FR_NOISE} frame_kind_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [7:0]  data_byte;
	logic        last_byte;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [2:0]  cfg_index;
	logic [15:0] cfg_data;
	logic        out_valid;
	logic        out_stall;
	logic        is_status;
	logic [7:0]  kind;
	logic [7:0]  font_size;
	logic [7:0]  color;
	logic [31:0] duration_s;
	logic [31:0] received_at;
	logic [7:0]  id_length;
	logic [7:0]  title_length;
	logic [15:0] value_length;
	logic [7:0]  entry_index;
	logic [3:0]  status_code;
	logic [7:0]  entry_count;

	queue_frame_validator_unit i_dut (.*);

	// register copies
	logic [7:0]  newest_version_r, max_entries_r, id_max_r, title_max_r;
	logic [15:0] value_max_r;

	// frame state copies
	logic [7:0]  dly [4];
	logic [31:0] fnv;
	logic [31:0] pos;
	qfv_pkg::phase_t  phase;
	logic [1:0]  fbi;
	logic [7:0]  version_seen, count_seen, entries_seen;
	logic [15:0] text_left;
	logic        text_long;
	qfv_pkg::status_t err;
	frame_res_t  entry;

	frame_res_t  expected_results[$];
	logic [7:0]  fbuf[$];
	int          idle_pct, stall_pct, bytes_sent, mismatches;

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	function automatic void clear_frame();
		foreach (dly[i]) dly[i] = 8'd0;
		fnv = qfv_pkg::FNV_BASIS;
		pos = '0;
		phase = qfv_pkg::PH_MAGIC0;
		fbi = '0;
		version_seen = '0;
		count_seen = '0;
		entries_seen = '0;
		text_left = '0;
		text_long = 1'b0;
		err = qfv_pkg::ST_OK;
		entry = '0;
	endfunction

	function automatic bit end_text();
		if (text_long) begin
			err = qfv_pkg::ST_TEXT_LONG;
			return 0;
		end
		if (phase == qfv_pkg::PH_IDTEXT) begin
			phase = qfv_pkg::PH_TITLELEN;
		end else if (phase == qfv_pkg::PH_TITLETEXT) begin
			phase = qfv_pkg::PH_VALLEN;
			fbi = '0;
		end else begin
			entries_seen = entries_seen + 8'd1;
			phase = (entries_seen == count_seen) ? qfv_pkg::PH_DONE : qfv_pkg::PH_KIND;
			return 1;
		end
		return 0;
	endfunction

	function automatic bit begin_text(logic [15:0] len, logic [15:0] lim,
		qfv_pkg::phase_t nxt);
		phase = nxt;
		text_left = len;
		text_long = len > lim;
		if (len == 16'd0)
			return end_text();
		return 0;
	endfunction

	function automatic bit parse(logic [7:0] x);
		if (err != qfv_pkg::ST_OK)
			return 0;
		case (phase)
			qfv_pkg::PH_MAGIC0: begin
				if (x != qfv_pkg::MAGIC_S) err = qfv_pkg::ST_MAGIC;
				else phase = qfv_pkg::PH_MAGIC1;
			end
			qfv_pkg::PH_MAGIC1: begin
				if (x != qfv_pkg::MAGIC_Q) err = qfv_pkg::ST_MAGIC;
				else phase = qfv_pkg::PH_VERSION;
			end
			qfv_pkg::PH_VERSION: begin
				version_seen = x;
				if (x < 8'd1 || x > newest_version_r) err = qfv_pkg::ST_VERSION;
				else phase = qfv_pkg::PH_COUNT;
			end
			qfv_pkg::PH_COUNT: begin
				count_seen = x;
				if (x > max_entries_r) err = qfv_pkg::ST_COUNT;
				else phase = (x == 8'd0) ? qfv_pkg::PH_DONE : qfv_pkg::PH_KIND;
			end
			qfv_pkg::PH_KIND: begin
				entry = '0;
				entry.kind = x;
				phase = qfv_pkg::PH_FONT;
			end
			qfv_pkg::PH_FONT: begin
				entry.font_size = x;
				phase = qfv_pkg::PH_COLOR;
			end
			qfv_pkg::PH_COLOR: begin
				entry.color = x;
				phase = qfv_pkg::PH_DURATION;
				fbi = '0;
			end
			qfv_pkg::PH_DURATION: begin
				entry.duration_s[8*fbi +: 8] = x;
				if (fbi == 2'd3) begin
					phase = (version_seen >= qfv_pkg::VERSION_RECEIVED) ?
						qfv_pkg::PH_RECEIVED : qfv_pkg::PH_IDLEN;
				end
				fbi = fbi + 2'd1;
			end
			qfv_pkg::PH_RECEIVED: begin
				entry.received_at[8*fbi +: 8] = x;
				if (fbi == 2'd3)
					phase = qfv_pkg::PH_IDLEN;
				fbi = fbi + 2'd1;
			end
			qfv_pkg::PH_IDLEN: begin
				entry.id_length = x;
				return begin_text({8'd0, x}, {8'd0, id_max_r}, qfv_pkg::PH_IDTEXT);
			end
			qfv_pkg::PH_TITLELEN: begin
				entry.title_length = x;
				return begin_text({8'd0, x}, {8'd0, title_max_r}, qfv_pkg::PH_TITLETEXT);
			end
			qfv_pkg::PH_VALLEN: begin
				if (fbi == 2'd0) begin
					entry.value_length[7:0] = x;
					fbi = 2'd1;
					return 0;
				end
				entry.value_length[15:8] = x;
				fbi = '0;
				return begin_text(entry.value_length, value_max_r, qfv_pkg::PH_VALTEXT);
			end
			qfv_pkg::PH_IDTEXT, qfv_pkg::PH_TITLETEXT, qfv_pkg::PH_VALTEXT: begin
				text_left = text_left - 16'd1;
				if (text_left == 16'd0)
					return end_text();
			end
			default: err = qfv_pkg::ST_TRAILING;
		endcase
		return 0;
	endfunction

	function automatic bit validate_byte(logic [7:0] b, logic l, output frame_res_t r);
		bit done_entry;
		logic [31:0] sum;
		qfv_pkg::status_t code;
		done_entry = 0;
		r = '0;
		if (pos >= 32'd4) begin
			fnv = (fnv ^ {24'd0, dly[0]}) * qfv_pkg::FNV_PRIME;
			done_entry = parse(dly[0]) && err == qfv_pkg::ST_OK;
		end
		dly[0] = dly[1];
		dly[1] = dly[2];
		dly[2] = dly[3];
		dly[3] = b;
		if (pos != '1)
			pos = pos + 32'd1;
		if (done_entry) begin
			r = entry;
			r.entry_index = entries_seen - 8'd1;
		end
		if (!l)
			return done_entry;
		sum = {dly[3], dly[2], dly[1], dly[0]};
		if (pos < 32'd8) code = qfv_pkg::ST_SHORT;
		else if (sum != fnv) code = qfv_pkg::ST_CHECKSUM;
		else if (err != qfv_pkg::ST_OK) code = err;
		else if (phase != qfv_pkg::PH_DONE) code = qfv_pkg::ST_TRUNCATED;
		else code = qfv_pkg::ST_OK;
		r.is_status = 1'b1;
		r.status_code = code;
		r.entry_count = count_seen;
		clear_frame();
		return 1;
	endfunction

	task automatic send_byte(logic [7:0] b, logic l);
		frame_res_t r;
		if ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= b;
		last_byte <= l;
		do @(posedge clk); while (in_stall);
		bytes_sent++;
		if (validate_byte(b, l, r))
			expected_results.push_back(r);
	endtask

	always @(posedge clk) out_stall <= ($urandom_range(99) < stall_pct);

	task automatic check_field(string nm, logic [31:0] e, logic [31:0] a);
		if (e !== a) begin
			mismatches++;
			$display("%0t %s expected %0h actual %0h", $time, nm, e, a);
		end
	endtask

	always @(posedge clk) begin
		frame_res_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_results.size() == 0) begin
				mismatches++;
				$display("%0t unexpected result transfer, expected none actual status %0b code %0d",
					$time, is_status, status_code);
			end else begin
				e = expected_results.pop_front();
				check_field("is_status", 32'(e.is_status), 32'(is_status));
				check_field("kind", 32'(e.kind), 32'(kind));
				check_field("font_size", 32'(e.font_size), 32'(font_size));
				check_field("color", 32'(e.color), 32'(color));
				check_field("duration_s", e.duration_s, duration_s);
				check_field("received_at", e.received_at, received_at);
				check_field("id_length", 32'(e.id_length), 32'(id_length));
				check_field("title_length", 32'(e.title_length), 32'(title_length));
				check_field("value_length", 32'(e.value_length), 32'(value_length));
				check_field("entry_index", 32'(e.entry_index), 32'(entry_index));
				check_field("status_code", 32'(e.status_code), 32'(status_code));
				check_field("entry_count", 32'(e.entry_count), 32'(entry_count));
			end
		end
	end

	task automatic drain();
		in_valid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(qfv_pkg::reg_index_t idx, logic [15:0] v);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			qfv_pkg::REG_NEWEST_VERSION: newest_version_r = v[7:0];
			qfv_pkg::REG_MAX_ENTRIES: max_entries_r = v[7:0];
			qfv_pkg::REG_ID_MAX: id_max_r = v[7:0];
			qfv_pkg::REG_TITLE_MAX: title_max_r = v[7:0];
			qfv_pkg::REG_VALUE_MAX: value_max_r = v;
			default: ;
		endcase
	endtask

	task automatic set_regs(logic [7:0] nv, logic [7:0] me, logic [7:0] im, logic [7:0] tm,
		logic [15:0] vm);
		write_reg(qfv_pkg::REG_NEWEST_VERSION, {8'd0, nv});
		write_reg(qfv_pkg::REG_MAX_ENTRIES, {8'd0, me});
		write_reg(qfv_pkg::REG_ID_MAX, {8'd0, im});
		write_reg(qfv_pkg::REG_TITLE_MAX, {8'd0, tm});
		write_reg(qfv_pkg::REG_VALUE_MAX, vm);
		cfg_valid <= 1'b0;
	endtask

	task automatic start_body(logic [7:0] ver, logic [7:0] n);
		fbuf = {qfv_pkg::MAGIC_S, qfv_pkg::MAGIC_Q, ver, n};
	endtask

	task automatic add_entry(logic [7:0] ver, int il, int tl, int vl);
		repeat (7) fbuf.push_back(8'($urandom));
		if (ver >= qfv_pkg::VERSION_RECEIVED)
			repeat (4) fbuf.push_back(8'($urandom));
		fbuf.push_back(8'(il));
		repeat (il) fbuf.push_back(8'($urandom));
		fbuf.push_back(8'(tl));
		repeat (tl) fbuf.push_back(8'($urandom));
		fbuf.push_back(8'(vl));
		fbuf.push_back(8'(vl >> 8));
		repeat (vl) fbuf.push_back(8'($urandom));
	endtask

	task automatic finish_frame(bit bad_sum);
		logic [31:0] h;
		h = qfv_pkg::FNV_BASIS;
		foreach (fbuf[i]) h = (h ^ {24'd0, fbuf[i]}) * qfv_pkg::FNV_PRIME;
		if (bad_sum)
			h = h ^ (32'd1 << $urandom_range(31));
		for (int i = 0; i < 4; i++) fbuf.push_back(h[8*i +: 8]);
	endtask

	task automatic send_frame();
		foreach (fbuf[i]) send_byte(fbuf[i], i == fbuf.size() - 1);
	endtask

	function automatic int pick_len(int lim);
		return $urandom_range(0, (lim + 1 > 6) ? 6 : lim + 1);
	endfunction

	task automatic random_frame();
		frame_kind_t fk;
		logic [7:0] ver, n;
		int sel;
		sel = $urandom_range(0, 11);
		fk = (sel < 6) ? FR_GOOD : frame_kind_t'(sel - 5);
		if (sel == 11)
			fk = FR_NOISE;
		if (fk == FR_NOISE) begin
			fbuf = {};
			repeat ($urandom_range(1, 12)) fbuf.push_back(8'($urandom));
			send_frame();
			return;
		end
		ver = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(1, 2));
		n = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 3));
		if (n > max_entries_r && $urandom_range(3) != 0)
			n = max_entries_r;
		if (n > 4)
			n = 8'($urandom_range(0, 4));
		start_body(ver, n);
		for (int i = 0; i < n; i++)
			add_entry(ver, pick_len(id_max_r), pick_len(title_max_r), pick_len(value_max_r));
		case (fk)
			FR_CORRUPT: begin
				sel = $urandom_range(0, fbuf.size() - 1);
				fbuf[sel] = fbuf[sel] ^ 8'($urandom_range(1, 255));
			end
			FR_CUT: repeat ($urandom_range(1, 3)) if (fbuf.size() > 1) void'(fbuf.pop_back());
			FR_EXTRA: repeat ($urandom_range(1, 3)) fbuf.push_back(8'($urandom));
			default: ;
		endcase
		finish_frame(fk == FR_BADSUM);
		send_frame();
	endtask

	task automatic test_good_frames();
		start_body(8'd2, 8'd2);
		add_entry(8'd2, 1, 2, 3);
		add_entry(8'd2, 32, 0, 0);
		finish_frame(0);
		send_frame();
		start_body(8'd1, 8'd1);
		add_entry(8'd1, 0, 0, 0);
		finish_frame(0);
		send_frame();
		start_body(8'd2, 8'd0);
		finish_frame(0);
		send_frame();
		drain();
	endtask

	task automatic test_header_errors();
		fbuf = {qfv_pkg::MAGIC_S, qfv_pkg::MAGIC_Q, 8'd2};
		send_frame();
		start_body(8'd2, 8'd0);
		finish_frame(1);
		send_frame();
		start_body(8'd2, 8'd0);
		fbuf[0] = 8'hFF;
		finish_frame(0);
		send_frame();
		start_body(8'd2, 8'd0);
		fbuf[1] = 8'h00;
		finish_frame(0);
		send_frame();
		start_body(8'd0, 8'd0);
		finish_frame(0);
		send_frame();
		start_body(8'd3, 8'd0);
		finish_frame(0);
		send_frame();
		start_body(8'd2, 8'd17);
		finish_frame(0);
		send_frame();
		drain();
	endtask

	task automatic test_entry_errors();
		set_regs(8'd2, 8'd16, 8'd3, 8'd3, 16'd3);
		start_body(8'd2, 8'd1);
		add_entry(8'd2, 4, 0, 0);
		finish_frame(0);
		send_frame();
		start_body(8'd2, 8'd1);
		add_entry(8'd2, 0, 4, 0);
		finish_frame(0);
		send_frame();
		start_body(8'd2, 8'd1);
		add_entry(8'd2, 0, 0, 4);
		finish_frame(0);
		send_frame();
		// frame ends inside an over-long value text
		start_body(8'd2, 8'd1);
		add_entry(8'd2, 0, 0, 3);
		fbuf[17] = 8'hFF;
		fbuf[18] = 8'hFF;
		finish_frame(0);
		send_frame();
		// trailing byte after the last entry
		start_body(8'd1, 8'd1);
		add_entry(8'd1, 1, 1, 1);
		fbuf.push_back(8'hA5);
		finish_frame(0);
		send_frame();
		// entry completes on the final byte of a truncated frame
		start_body(8'd2, 8'd2);
		add_entry(8'd2, 2, 1, 1);
		finish_frame(0);
		send_frame();
		drain();
	endtask

	task automatic test_register_extremes();
		set_regs(8'd1, 8'd0, 8'd0, 8'd0, 16'd0);
		start_body(8'd1, 8'd0);
		finish_frame(0);
		send_frame();
		start_body(8'd2, 8'd0);
		finish_frame(0);
		send_frame();
		start_body(8'd1, 8'd1);
		finish_frame(0);
		send_frame();
		drain();
		set_regs(8'd255, 8'd255, 8'd255, 8'd255, 16'hFFFF);
		start_body(8'd255, 8'd2);
		add_entry(8'd255, 5, 0, 6);
		add_entry(8'd255, 0, 4, 0);
		finish_frame(0);
		send_frame();
		drain();
		set_regs(8'd2, 8'd16, 8'd4, 8'd4, 16'd4);
		for (int i = 0; i < 2; i++) random_frame();
		drain();
	endtask

	task automatic run_phase(int idle, int stall, int nbytes);
		int start;
		idle_pct = idle;
		stall_pct = stall;
		start = bytes_sent;
		while (bytes_sent - start < nbytes) random_frame();
		drain();
	endtask

	task automatic test_random_traffic();
		run_phase(0, 0, 20);
		set_regs(8'($urandom_range(1, 3)), 8'($urandom_range(0, 5)), 8'($urandom_range(0, 6)),
			8'($urandom_range(0, 6)), 16'($urandom_range(0, 6)));
		run_phase(70, 0, 20);
		set_regs(8'd2, 8'd16, 8'd32, 8'd64, 16'd256);
		run_phase(0, 70, 20);
		set_regs(8'($urandom_range(1, 255)), 8'($urandom_range(0, 255)), 8'($urandom_range(0, 8)),
			8'($urandom_range(0, 8)), 16'($urandom_range(0, 8)));
		run_phase(30, 30, 20);
	endtask

	initial begin
		#2_000_000;
		$display("Mismatches found");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		data_byte = '0;
		last_byte = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		out_stall = 1'b0;
		idle_pct = 0;
		stall_pct = 0;
		bytes_sent = 0;
		mismatches = 0;
		newest_version_r = qfv_pkg::NEWEST_VERSION_RST;
		max_entries_r = qfv_pkg::MAX_ENTRIES_RST;
		id_max_r = qfv_pkg::ID_MAX_RST;
		title_max_r = qfv_pkg::TITLE_MAX_RST;
		value_max_r = qfv_pkg::VALUE_MAX_RST;
		clear_frame();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_good_frames();
		test_header_errors();
		test_entry_errors();
		test_register_extremes();
		test_random_traffic();
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

// ----- filelist.f -----
hw/rtl/qfv_pkg.sv
hw/rtl/qfv_parser.sv
hw/rtl/queue_frame_validator_unit.sv
test/tb_queue_frame_validator_unit.sv
